// ===== rtl/akd_pkg.sv =====
package akd_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 5;
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned MAX_BUTTONS     = 5;

  localparam int unsigned THR_W      = 10;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned BTN_W      = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned EVQ_DEPTH  = 2;
  localparam int unsigned CNT_W      = 2;

  localparam logic [BTN_W-1:0] NO_BUTTON = 3'd5;

  localparam logic [THR_W-1:0] THR_RESET [MAX_BUTTONS] = '{
    10'd30, 10'd150, 10'd360, 10'd535, 10'd760
  };
  localparam logic [DEB_W-1:0] DEB_RESET = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR0     = 3'd0,
    REG_THR1     = 3'd1,
    REG_THR2     = 3'd2,
    REG_THR3     = 3'd3,
    REG_THR4     = 3'd4,
    REG_DEBOUNCE = 3'd5
  } reg_idx_e;

  typedef enum logic {
    KIND_RELEASED = 1'b0,
    KIND_PRESSED  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [BTN_W-1:0] button;
    logic             last;
  } evt_t;

endpackage

// ===== rtl/akd_cfg.sv =====
module akd_cfg #(
  parameter int unsigned NUM_BUTTONS = akd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [akd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [akd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [akd_pkg::THR_W-1:0]       thr_o [NUM_BUTTONS],
  output logic [akd_pkg::DEB_W-1:0]       deb_o
);

  logic [akd_pkg::THR_W-1:0] thr_q [NUM_BUTTONS];
  logic [akd_pkg::DEB_W-1:0] deb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        thr_q[i] <= akd_pkg::THR_RESET[i];
      end
      deb_q <= akd_pkg::DEB_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == akd_pkg::REG_DEBOUNCE) begin
        deb_q <= cfg_data_i[akd_pkg::DEB_W-1:0];
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (cfg_idx_i == akd_pkg::CFG_IDX_W'(akd_pkg::REG_THR0) + akd_pkg::CFG_IDX_W'(i)) begin
          thr_q[i] <= cfg_data_i[akd_pkg::THR_W-1:0];
        end
      end
    end
  end

  assign thr_o = thr_q;
  assign deb_o = deb_q;

endmodule

// ===== rtl/akd_core.sv =====
module akd_core #(
  parameter int unsigned NUM_BUTTONS = akd_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned SAMPLE_BITS = akd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic [akd_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [akd_pkg::THR_W-1:0]     thr_i [NUM_BUTTONS],
  input  logic [akd_pkg::DEB_W-1:0]     deb_i,
  input  logic [akd_pkg::CNT_W-1:0]     room_i,
  output logic [akd_pkg::CNT_W-1:0]     push_n_o,
  output akd_pkg::evt_t                 ev0_o,
  output akd_pkg::evt_t                 ev1_o
);

  localparam int unsigned CmpW =
    (SAMPLE_BITS > akd_pkg::THR_W) ? SAMPLE_BITS : akd_pkg::THR_W;

  logic                         stg_vld_q;
  logic [SAMPLE_BITS-1:0]       smp_q;
  logic [akd_pkg::TIME_W-1:0]   now_q;

  logic [akd_pkg::BTN_W-1:0]    lat_q, lat_d;
  logic [akd_pkg::BTN_W-1:0]    acc_q, acc_d;
  logic                         wait_q, wait_d;
  logic [akd_pkg::TIME_W-1:0]   dl_q, dl_d;

  logic [akd_pkg::BTN_W-1:0]    cls;
  logic [akd_pkg::BTN_W-1:0]    lat;
  logic [akd_pkg::TIME_W-1:0]   dl;
  logic [akd_pkg::TIME_W-1:0]   diff;
  logic [akd_pkg::CNT_W-1:0]    evt_n;
  logic                         chg, passed, fire, rel, prs, adv;

  // The lowest-indexed threshold that the sample lies below wins.
  always_comb begin
    cls = akd_pkg::NO_BUTTON;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (CmpW'(smp_q) < CmpW'(thr_i[i])) begin
        cls = akd_pkg::BTN_W'(i);
      end
    end
  end

  // The deadline counts as passed while now - deadline stays in the lower half of the range.
  assign lat    = wait_q ? lat_q : cls;
  assign chg    = (lat != acc_q);
  assign dl     = wait_q ? dl_q : now_q + akd_pkg::TIME_W'(deb_i);
  assign diff   = now_q - dl;
  assign passed = !diff[akd_pkg::TIME_W-1];
  assign fire   = chg && passed;
  assign rel    = fire && (cls != acc_q) && (acc_q != akd_pkg::NO_BUTTON);
  assign prs    = fire && (cls != acc_q) && (cls != akd_pkg::NO_BUTTON);

  assign evt_n      = {1'b0, rel} + {1'b0, prs};
  assign adv        = stg_vld_q && (evt_n <= room_i);
  assign push_n_o   = adv ? evt_n : '0;
  assign in_ready_o = !stg_vld_q || adv;

  always_comb begin
    ev0_o.kind   = rel ? akd_pkg::KIND_RELEASED : akd_pkg::KIND_PRESSED;
    ev0_o.button = rel ? acc_q : cls;
    ev0_o.last   = !(rel && prs);
    ev1_o.kind   = akd_pkg::KIND_PRESSED;
    ev1_o.button = cls;
    ev1_o.last   = 1'b1;
  end

  always_comb begin
    lat_d  = (wait_q && !fire) ? lat_q : cls;
    acc_d  = acc_q;
    wait_d = wait_q;
    dl_d   = dl_q;
    if (chg && !wait_q) begin
      dl_d = dl;
    end
    if (chg) begin
      wait_d = !passed;
    end
    if (fire) begin
      acc_d = cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      lat_q     <= akd_pkg::NO_BUTTON;
      acc_q     <= akd_pkg::NO_BUTTON;
      wait_q    <= 1'b0;
      dl_q      <= '0;
    end else begin
      if (in_ready_o) begin
        stg_vld_q <= in_valid_i;
      end
      if (adv) begin
        lat_q  <= lat_d;
        acc_q  <= acc_d;
        wait_q <= wait_d;
        dl_q   <= dl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q <= sample_i;
      now_q <= now_ms_i;
    end
  end

endmodule

// ===== rtl/akd_evq.sv =====
module akd_evq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [akd_pkg::CNT_W-1:0]  push_n_i,
  input  akd_pkg::evt_t              ev0_i,
  input  akd_pkg::evt_t              ev1_i,
  output logic [akd_pkg::CNT_W-1:0]  room_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output akd_pkg::evt_t              out_ev_o
);

  akd_pkg::evt_t              ent_q [akd_pkg::EVQ_DEPTH];
  akd_pkg::evt_t              ent_d [akd_pkg::EVQ_DEPTH];
  logic [akd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [akd_pkg::CNT_W-1:0]  base;
  logic                       pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_ev_o    = ent_q[0];
  assign base        = cnt_q - akd_pkg::CNT_W'(pop);
  assign room_o      = akd_pkg::CNT_W'(akd_pkg::EVQ_DEPTH) - base;
  assign cnt_d       = base + push_n_i;

  always_comb begin
    ent_d = ent_q;
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (push_n_i != '0) begin
      if (base == '0) begin
        ent_d[0] = ev0_i;
        if (push_n_i == akd_pkg::CNT_W'(2)) begin
          ent_d[1] = ev1_i;
        end
      end else begin
        ent_d[1] = ev0_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== rtl/analog_keypad_debouncer_top.sv =====
// Keypad debouncer for a resistor-ladder keypad read through one converter.
// Input channel (in_valid_i / in_ready_o) carries one item: a sample and the
// millisecond time at which it was taken. Output channel (out_valid_o /
// out_ready_i) carries event items: a release of the old button and/or a
// press of the new one, with last_o set on the final event of an input item.
// Most items cause no event at all.
// An accepted item is registered, classified and checked against the
// debounce deadline in the following cycle; its events enter the two-entry
// event queue, which offers the first. One item is taken every cycle while the
// queue has room for the registered item's events; two events fill both entries.
// When the receiver stalls, items causing no event keep flowing; an item with
// events waits in the input register until the queue has room for them all.
// The configuration port writes thresholds and the debounce time, with no
// read-back. Reset restores the default thresholds and debounce time, clears
// the debounce state to "no button" and empties the queue; no clearing pass runs.
module analog_keypad_debouncer_top #(
  parameter int unsigned NUM_BUTTONS = akd_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned SAMPLE_BITS = akd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [akd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [akd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  input  logic [akd_pkg::TIME_W-1:0]      now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            event_kind_o,
  output logic [akd_pkg::BTN_W-1:0]       button_o,
  output logic                            last_o
);

  logic [akd_pkg::THR_W-1:0]  thr [NUM_BUTTONS];
  logic [akd_pkg::DEB_W-1:0]  deb;
  logic [akd_pkg::CNT_W-1:0]  room;
  logic [akd_pkg::CNT_W-1:0]  push_n;
  akd_pkg::evt_t              ev0, ev1, out_ev;

  akd_cfg #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .thr_o     (thr),
    .deb_o     (deb)
  );

  akd_core #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i  (sample_i),
    .now_ms_i  (now_ms_i),
    .thr_i     (thr),
    .deb_i     (deb),
    .room_i    (room),
    .push_n_o  (push_n),
    .ev0_o     (ev0),
    .ev1_o     (ev1)
  );

  akd_evq u_evq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .ev0_i      (ev0),
    .ev1_i      (ev1),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_ev_o   (out_ev)
  );

  assign event_kind_o = out_ev.kind;
  assign button_o     = out_ev.button;
  assign last_o       = out_ev.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> (push_n <= room))
    else $error("event queue overflow");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n == akd_pkg::CNT_W'(2)) |->
      (ev0.kind == akd_pkg::KIND_RELEASED && !ev0.last && ev0.button != ev1.button))
    else $error("event pair out of order");

  a_real_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (button_o != akd_pkg::NO_BUTTON))
    else $error("event for no button");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("event queue not empty after reset");

endmodule

// ===== verif/analog_keypad_debouncer_top_test.sv =====
module analog_keypad_debouncer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import akd_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int ITEMS_TARGET = 900;
  localparam int STALL_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PERCENT = 35;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SB-1:0]         sample_i;
  logic [TIME_W-1:0]     now_ms_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  event_kind_o;
  logic [BTN_W-1:0]      button_o;
  logic                  last_o;

  analog_keypad_debouncer_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sample_i(sample_i),
    .now_ms_i(now_ms_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .event_kind_o(event_kind_o),
    .button_o(button_o),
    .last_o(last_o)
  );

  // Predicted debounce state and register copies.
  logic [THR_W-1:0]  kp_thr [MAX_BUTTONS];
  logic [DEB_W-1:0]  kp_debounce;
  logic [BTN_W-1:0]  kp_latched;
  logic [BTN_W-1:0]  kp_accepted;
  logic [BTN_W-1:0]  kp_held;
  logic              kp_waiting;
  logic [TIME_W-1:0] kp_deadline;

  evt_t expected_events[$];

  logic [TIME_W-1:0] clock_ms;
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;
  int items_sent;
  int double_items;
  int presses_seen;
  int releases_seen;
  int settings_used;
  int mismatches;
  int stuck_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [BTN_W-1:0] ladder_button(input logic [SB-1:0] s);
    for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
      if (s < kp_thr[i]) return BTN_W'(i);
    end
    return NO_BUTTON;
  endfunction

  function automatic logic [SB-1:0] sample_for(input logic [BTN_W-1:0] target);
    logic [SB-1:0] s;
    s = SB'($urandom);
    for (int k = 0; k < 256; k++) begin
      if (ladder_button(s) == target) return s;
      s = SB'($urandom);
    end
    return s;
  endfunction

  function automatic logic [TIME_W-1:0] time_step();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return $urandom;
    if (pick < 4) return kp_debounce + $urandom_range(0, 3);
    return $urandom_range(0, kp_debounce / 2 + 1);
  endfunction

  task automatic predict_key_events(input logic [SB-1:0] s, input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] overdue;
    logic pressing;
    logic releasing;
    evt_t ev;
    if (!kp_waiting) kp_latched = ladder_button(s);
    if (kp_latched == kp_accepted) return;
    if (!kp_waiting) begin
      kp_waiting = 1'b1;
      kp_deadline = t + TIME_W'(kp_debounce);
    end
    overdue = t - kp_deadline;
    if (overdue[TIME_W-1]) return;
    kp_waiting = 1'b0;
    kp_latched = ladder_button(s);
    if (kp_latched == kp_accepted) return;
    kp_accepted = kp_latched;
    releasing = (kp_latched != kp_held) && (kp_held != NO_BUTTON);
    pressing = (kp_latched != NO_BUTTON);
    if (releasing) begin
      ev.kind = KIND_RELEASED;
      ev.button = kp_held;
      ev.last = !pressing;
      expected_events.push_back(ev);
    end
    kp_held = kp_latched;
    if (pressing) begin
      ev.kind = KIND_PRESSED;
      ev.button = kp_latched;
      ev.last = 1'b1;
      expected_events.push_back(ev);
    end
    if (releasing && pressing) double_items++;
  endtask

  task automatic send_sample(input logic [SB-1:0] s, input logic [TIME_W-1:0] t);
    while (!tx_calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    now_ms_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    predict_key_events(s, t);
    items_sent++;
  endtask

  task automatic wait_for_events();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx < REG_DEBOUNCE) kp_thr[idx] = data[THR_W-1:0];
    else if (idx == REG_DEBOUNCE) kp_debounce = data;
  endtask

  task automatic set_ladder(input logic [CFG_DATA_W-1:0] t0, input logic [CFG_DATA_W-1:0] t1,
                            input logic [CFG_DATA_W-1:0] t2, input logic [CFG_DATA_W-1:0] t3,
                            input logic [CFG_DATA_W-1:0] t4, input logic [CFG_DATA_W-1:0] deb);
    write_reg(REG_THR0, t0);
    write_reg(REG_THR1, t1);
    write_reg(REG_THR2, t2);
    write_reg(REG_THR3, t3);
    write_reg(REG_THR4, t4);
    write_reg(REG_DEBOUNCE, deb);
    settings_used++;
  endtask

  // A key held in one band for a few samples, with the odd bounce.
  task automatic hold_button_seq();
    logic [BTN_W-1:0] target;
    logic [SB-1:0] s;
    int reps;
    target = BTN_W'($urandom_range(0, 5));
    reps = $urandom_range(1, 5);
    for (int k = 0; k < reps; k++) begin
      s = ($urandom_range(0, 9) == 0) ? SB'($urandom) : sample_for(target);
      clock_ms += time_step();
      send_sample(s, clock_ms);
    end
  endtask

  task automatic noise_sample();
    logic [TIME_W-1:0] t;
    if ($urandom_range(0, 3) == 0) begin
      t = $urandom;
    end else begin
      clock_ms += time_step();
      t = clock_ms;
    end
    send_sample(SB'($urandom), t);
  endtask

  task automatic random_burst(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) hold_button_seq();
      else noise_sample();
    end
  endtask

  // Reset thresholds and debounce time, band edges, bounces and a deadline across the wrap.
  task automatic test_directed_reset_values();
    send_sample(10'd0, 32'd100);
    send_sample(10'd0, 32'd149);
    send_sample(10'd0, 32'd150);
    send_sample(10'd29, 32'd160);
    send_sample(10'd30, 32'd170);
    send_sample(10'd1023, 32'd200);
    send_sample(10'd1023, 32'd220);
    send_sample(10'd359, 32'd230);
    send_sample(10'd5, 32'd280);
    send_sample(10'd200, 32'd300);
    send_sample(10'd10, 32'd350);
    send_sample(10'd534, 32'd400);
    send_sample(10'd534, 32'd450);
    send_sample(10'd759, 32'd500);
    send_sample(10'd759, 32'd550);
    send_sample(10'd760, 32'd600);
    send_sample(10'd760, 32'd650);
    send_sample(10'd0, 32'hFFFF_FFF0);
    send_sample(10'd0, 32'hFFFF_FFFF);
    send_sample(10'd0, 32'h0000_0030);
    clock_ms = 32'h0000_0040;
    settings_used++;
  endtask

  task automatic test_register_extremes();
    wait_for_events();
    set_ladder(16'd30, 16'd150, 16'd360, 16'd535, 16'd760, 16'd0);
    random_burst(35);
    wait_for_events();
    set_ladder(16'hFC64, 16'h80C8, 16'h412C, 16'h0190, 16'hFDF4, 16'd7);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, 16'hFFFF);
    random_burst(35);
    wait_for_events();
    set_ladder(16'd900, 16'd100, 16'd600, 16'd50, 16'd1023, 16'd3);
    random_burst(35);
    wait_for_events();
    set_ladder(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    random_burst(35);
    wait_for_events();
    set_ladder(16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'hFFFF);
    random_burst(40);
  endtask

  // Every item changes the key with no debounce, so each one raises events.
  task automatic test_receiver_backpressure();
    logic [BTN_W-1:0] target;
    wait_for_events();
    set_ladder(16'd30, 16'd150, 16'd360, 16'd535, 16'd760, 16'd0);
    tx_calm = 1'b1;
    rx_hold_req = 1'b1;
    repeat (40) begin
      target = BTN_W'((kp_accepted + 1 + $urandom_range(0, 4)) % 6);
      clock_ms += 1;
      send_sample(sample_for(target), clock_ms);
    end
    tx_calm = 1'b0;
    wait_for_events();
    random_burst(20);
  endtask

  task automatic test_random_ladders();
    int unsigned cuts[$];
    int phase;
    logic [CFG_DATA_W-1:0] deb;
    phase = 0;
    while (items_sent < ITEMS_TARGET) begin
      wait_for_events();
      cuts.delete();
      repeat (5) cuts.push_back($urandom_range(0, 1023));
      cuts.sort();
      case ($urandom_range(0, 2))
        0: deb = 16'd0;
        1: deb = CFG_DATA_W'($urandom_range(1, 40));
        default: deb = CFG_DATA_W'($urandom_range(100, 400));
      endcase
      set_ladder(CFG_DATA_W'(cuts[0]), CFG_DATA_W'(cuts[1]), CFG_DATA_W'(cuts[2]),
                 CFG_DATA_W'(cuts[3]), CFG_DATA_W'(cuts[4]), deb);
      tx_calm = (phase == 2);
      rx_calm = (phase == 2);
      random_burst(120);
      phase++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] event mismatch: %s", $realtime, msg);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold_left = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rx_calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i) begin : check_events
    evt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (event_kind_o == KIND_PRESSED) presses_seen++;
      else releases_seen++;
      if (expected_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected kind=%0b button=%0d last=%0b",
                                event_kind_o, button_o, last_o));
      end else begin
        want = expected_events.pop_front();
        if (want.kind !== event_kind_o || want.button !== button_o || want.last !== last_o) begin
          flag_mismatch($sformatf("expected kind=%0b button=%0d last=%0b, got kind=%0b button=%0d last=%0b",
                                  want.kind, want.button, want.last,
                                  event_kind_o, button_o, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stuck_cycles = 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
        $display("Run stalled for %0d cycles with %0d events outstanding.",
                 stuck_cycles, expected_events.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles++;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    now_ms_i = '0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold_req = 1'b0;
    items_sent = 0;
    double_items = 0;
    presses_seen = 0;
    releases_seen = 0;
    settings_used = 0;
    mismatches = 0;
    stuck_cycles = 0;
    clock_ms = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) kp_thr[i] = THR_RESET[i];
    kp_debounce = DEB_RESET;
    kp_latched = NO_BUTTON;
    kp_accepted = NO_BUTTON;
    kp_held = NO_BUTTON;
    kp_waiting = 1'b0;
    kp_deadline = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_reset_values();
    test_register_extremes();
    test_receiver_backpressure();
    test_random_ladders();
    wait_for_events();

    $display("Sent %0d samples under %0d threshold settings; %0d items gave two events.",
             items_sent, settings_used, double_items);
    $display("Checked %0d press and %0d release events.", presses_seen, releases_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
